@@ sv/gto_pkg.sv @@
// Shared types for the GPS track odometer: command codes, sequencer states
// and the status bundle of the iterative arithmetic units. No dependencies.
package gto_pkg;

	typedef enum logic [1:0] {
		MODE_START  = 2'd0,
		MODE_DATA   = 2'd1,
		MODE_STOP   = 2'd2,
		MODE_IGNORE = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAGX,
		ST_MAGY,
		ST_SQY,
		ST_ROOTGO,
		ST_ROOTWAIT,
		ST_DIVGO,
		ST_DIVWAIT,
		ST_DONE
	} state_t;

	// busy while iterating, done for one cycle once the result register holds
	typedef struct packed {
		logic busy;
		logic done;
	} unit_status_t;

endpackage

@@ sv/gps_track_odometer_unit.sv @@
// Top level of the GPS track odometer: command sequencer, shared squarer and
// accumulators. Depends on gto_pkg, gto_isqrt and gto_div.
//
// Usage: the input channel (in_valid/in_ready) carries one command per
// transaction: mode (start, data, stop, ignore) and a signed coordinate pair
// with 8 fraction bits. Every input transaction yields exactly one output
// transaction (out_valid/out_ready) that shows the track state after the
// command: flags, path length, start-distance sum, point count and, once the
// track is stopped, the end point, return distance and mean start distance.
// Flow: start, ignored and rejected commands go from idle straight to the
// final step that loads the output register. Data points take two distance
// passes (magnitudes, two squares on one multiplier, then COORD_WIDTH+2
// square-root steps). A stop then divides the start-distance sum by the
// point count, one quotient bit per cycle in the divider. in_ready is high
// only while the sequencer idles, so one transaction is in work at a time.
// The output register holds a result while the receiver stalls; the next
// command is accepted and computed meanwhile and waits at its final step.
// Reset (arst_n low) clears the track: not started, all sums and points zero.
module gps_track_odometer_unit import gto_pkg::*; #(
	parameter int COORD_WIDTH = 24,
	parameter int ACC_WIDTH   = 40,
	parameter int COUNT_WIDTH = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          accepted,
	output logic                          is_started,
	output logic                          is_stopped,
	output logic [ACC_WIDTH-1:0]          path_length,
	output logic [ACC_WIDTH-1:0]          start_distance_sum,
	output logic [COUNT_WIDTH-1:0]        point_count,
	output logic signed [COORD_WIDTH-1:0] final_x,
	output logic signed [COORD_WIDTH-1:0] final_y,
	output logic [COORD_WIDTH:0]          return_distance,
	output logic [ACC_WIDTH-1:0]          mean_start_distance
);

	localparam int MAG_W = COORD_WIDTH + 1;       // |a - b| of two coordinates
	localparam int SQ_W  = 2 * MAG_W;             // one square
	localparam int RAD_W = SQ_W + 1;              // sum of two squares
	localparam int STEPS = (RAD_W + 1) / 2;       // root width
	localparam int RT_W  = COORD_WIDTH + 1;       // distances never exceed this
	localparam int SUM_W = ((ACC_WIDTH > RT_W) ? ACC_WIDTH : RT_W) + 1;

	state_t state_q, state_d;

	// track state
	logic [COORD_WIDTH-1:0] origin_x_q, origin_y_q, prev_x_q, prev_y_q;
	logic [COORD_WIDTH-1:0] end_x_q, end_y_q;
	logic [ACC_WIDTH-1:0]   length_q, sdist_q, mean_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [RT_W-1:0]        retd_q;
	logic                   started_q, stopped_q;

	// command in work
	mode_t                  mode_q;
	logic [COORD_WIDTH-1:0] x_q, y_q;
	logic                   acc_q;
	logic                   pass_q;   // 0: step from previous, 1: distance to origin

	// distance datapath
	logic [COORD_WIDTH-1:0] op_a, op_r;
	logic [MAG_W-1:0]       diff, mag_d, mag_q;
	logic [SQ_W-1:0]        prod, sq1_q, sq2_q;
	logic [RAD_W-1:0]       radicand;
	logic [STEPS-1:0]       root;
	logic [RT_W-1:0]        root_dist;
	logic [ACC_WIDTH-1:0]   acc_sel, sat_val;
	logic [SUM_W-1:0]       sum_w;
	logic [COUNT_WIDTH-1:0] count_inc;
	logic [ACC_WIDTH-1:0]   quotient;

	// output register
	logic                   out_valid_q;
	logic                   acc_o_q, started_o_q, stopped_o_q;
	logic [ACC_WIDTH-1:0]   length_o_q, sdist_o_q, mean_o_q;
	logic [COUNT_WIDTH-1:0] count_o_q;
	logic [COORD_WIDTH-1:0] end_x_o_q, end_y_o_q;
	logic [RT_W-1:0]        retd_o_q;

	mode_t        cmd;
	logic         in_fire, do_start, do_point;
	logic         sq_start, div_start, out_load;
	unit_status_t sq_st, div_st;

	assign cmd      = mode_t'(mode);
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign do_start = (cmd == MODE_START) && !started_q && !stopped_q;
	assign do_point = ((cmd == MODE_DATA) || (cmd == MODE_STOP)) && started_q && !stopped_q;

	// one subtractor serves both axes; reference is previous point or origin
	always_comb begin
		op_a = (state_q == ST_MAGX) ? x_q : y_q;
		if (pass_q) begin
			op_r = (state_q == ST_MAGX) ? origin_x_q : origin_y_q;
		end else begin
			op_r = (state_q == ST_MAGX) ? prev_x_q : prev_y_q;
		end
		diff  = {op_a[COORD_WIDTH-1], op_a} - {op_r[COORD_WIDTH-1], op_r};
		mag_d = diff[MAG_W-1] ? ((~diff) + MAG_W'(1)) : diff;
	end

	// the single shared squarer
	assign prod      = mag_q * mag_q;
	assign radicand  = {1'b0, sq1_q} + {1'b0, sq2_q};
	assign root_dist = root[RT_W-1:0];

	// saturating accumulate of the fresh distance into the sum of this pass
	assign acc_sel   = pass_q ? sdist_q : length_q;
	assign sum_w     = SUM_W'(acc_sel) + SUM_W'(root_dist);
	assign sat_val   = (sum_w[SUM_W-1:ACC_WIDTH] != '0) ? '1 : sum_w[ACC_WIDTH-1:0];
	assign count_inc = (&count_q) ? count_q : count_q + 1'b1;

	gto_isqrt #(
		.IN_W (RAD_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (radicand),
		.root     (root),
		.status   (sq_st)
	);

	gto_div #(
		.DVD_W (ACC_WIDTH),
		.DVS_W (COUNT_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sdist_q),
		.divisor  (count_q),
		.quotient (quotient),
		.status   (div_st)
	);

	// sequencer
	always_comb begin
		state_d   = state_q;
		sq_start  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = do_point ? ST_MAGX : ST_DONE;
				end
			end
			ST_MAGX:   state_d = ST_MAGY;
			ST_MAGY:   state_d = ST_SQY;
			ST_SQY:    state_d = ST_ROOTGO;
			ST_ROOTGO: begin
				sq_start = 1'b1;
				state_d  = ST_ROOTWAIT;
			end
			ST_ROOTWAIT: begin
				if (sq_st.done) begin
					if (!pass_q) begin
						state_d = ST_MAGX;
					end else if (mode_q == MODE_STOP) begin
						state_d = ST_DIVGO;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DIVGO: begin
				// an empty count leaves the mean at zero
				div_start = (count_q != '0);
				state_d   = (count_q != '0) ? ST_DIVWAIT : ST_DONE;
			end
			ST_DIVWAIT: begin
				if (div_st.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold the result until the output register frees up
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			pass_q      <= 1'b0;
			started_q   <= 1'b0;
			stopped_q   <= 1'b0;
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			end_x_q     <= '0;
			end_y_q     <= '0;
			length_q    <= '0;
			sdist_q     <= '0;
			count_q     <= '0;
			retd_q      <= '0;
			mean_q      <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						pass_q <= 1'b0;
						if (do_start) begin
							origin_x_q <= coord_x;
							origin_y_q <= coord_y;
							prev_x_q   <= coord_x;
							prev_y_q   <= coord_y;
							started_q  <= 1'b1;
						end
					end
				end
				ST_ROOTWAIT: begin
					if (sq_st.done) begin
						if (!pass_q) begin
							length_q <= sat_val;
							pass_q   <= 1'b1;
						end else begin
							sdist_q <= sat_val;
							count_q <= count_inc;
							if (mode_q == MODE_STOP) begin
								end_x_q   <= x_q;
								end_y_q   <= y_q;
								stopped_q <= 1'b1;
								retd_q    <= root_dist;
							end else begin
								prev_x_q <= x_q;
								prev_y_q <= y_q;
							end
						end
					end
				end
				ST_DIVWAIT: begin
					if (div_st.done) begin
						mean_q <= quotient;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q <= cmd;
			x_q    <= coord_x;
			y_q    <= coord_y;
			acc_q  <= do_start || do_point;
		end
		case (state_q)
			ST_MAGX: mag_q <= mag_d;
			ST_MAGY: begin
				sq1_q <= prod;
				mag_q <= mag_d;
			end
			ST_SQY:  sq2_q <= prod;
			default: ;
		endcase
		if (out_load) begin
			acc_o_q     <= acc_q;
			started_o_q <= started_q;
			stopped_o_q <= stopped_q;
			length_o_q  <= length_q;
			sdist_o_q   <= sdist_q;
			count_o_q   <= count_q;
			end_x_o_q   <= end_x_q;
			end_y_o_q   <= end_y_q;
			retd_o_q    <= retd_q;
			mean_o_q    <= mean_q;
		end
	end

	assign out_valid           = out_valid_q;
	assign accepted            = acc_o_q;
	assign is_started          = started_o_q;
	assign is_stopped          = stopped_o_q;
	assign path_length         = length_o_q;
	assign start_distance_sum  = sdist_o_q;
	assign point_count         = count_o_q;
	assign final_x             = end_x_o_q;
	assign final_y             = end_y_o_q;
	assign return_distance     = retd_o_q;
	assign mean_start_distance = mean_o_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> started_q)
		else $error("track stopped without being started");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !stopped_o_q) |-> (retd_o_q == '0 && mean_o_q == '0))
		else $error("stop results nonzero before stop");

	assert property (@(posedge clk) disable iff (!arst_n)
		sq_st.done |-> (state_q == ST_ROOTWAIT))
		else $error("square root finished outside its wait state");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!sq_st.busy && !div_st.busy))
		else $error("ready while an arithmetic unit is busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROOTWAIT && sq_st.done && pass_q && mode_q == MODE_STOP)
		|=> (stopped_q && count_q != '0))
		else $error("stop did not close the track with a nonzero count");
`endif

endmodule

@@ sv/gto_isqrt.sv @@
// Iterative integer square root, one radicand bit pair per cycle.
// Depends on gto_pkg for the unit status bundle.
module gto_isqrt import gto_pkg::*; #(
	parameter int IN_W = 51
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [IN_W-1:0]          radicand,
	output logic [(IN_W+1)/2-1:0]    root,
	output unit_status_t             status
);

	localparam int STEPS = (IN_W + 1) / 2;
	localparam int PAD_W = 2 * STEPS;
	localparam int REM_W = STEPS + 3;
	localparam int CNT_W = $clog2(STEPS);

	logic [PAD_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic [STEPS-1:0] root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	// bring down the next bit pair, trial subtract 4*root+1
	assign rem_sh = {rem_q[REM_W-3:0], rad_q[PAD_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= PAD_W'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[PAD_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[STEPS-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[STEPS-2:0], 1'b0};
			end
		end
	end

	assign root        = root_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

@@ sv/gto_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on gto_pkg for the unit status bundle.
module gto_div import gto_pkg::*; #(
	parameter int DVD_W = 40,
	parameter int DVS_W = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic [DVD_W-1:0] quotient,
	output unit_status_t     status
);

	localparam int CNT_W = $clog2(DVD_W);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   rem_sh;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	assign rem_sh = {rem_q, quo_q[DVD_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (rem_sh >= {1'b0, dvs_q}) begin
				rem_q <= DVS_W'(rem_sh - {1'b0, dvs_q});
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

@@ verif/tb.sv @@
// Self-checking bench for gps_track_odometer_unit: a driver and a monitor run
// against an in-bench predictor of one track. Depends on gto_pkg and the RTL top.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gto_pkg::*;

	localparam int CW = 24;
	localparam int AW = 40;
	localparam int NW = 24;
	localparam logic [AW-1:0] ACC_MAX = {AW{1'b1}};
	localparam logic [NW-1:0] CNT_MAX = {NW{1'b1}};
	localparam logic signed [CW-1:0] XY_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] XY_MAX = {1'b0, {(CW-1){1'b1}}};

	// one command as offered on the input channel
	typedef struct {
		mode_t                cmd;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		bit                   drain_first;
	} track_cmd_t;

	// track state as shown on the output channel
	typedef struct {
		logic                 took;
		logic                 started;
		logic                 stopped;
		logic [AW-1:0]        length;
		logic [AW-1:0]        org_sum;
		logic [NW-1:0]        points;
		logic signed [CW-1:0] fin_x;
		logic signed [CW-1:0] fin_y;
		logic [CW:0]          ret_dist;
		logic [AW-1:0]        mean_dist;
	} track_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [1:0]           mode = MODE_IGNORE;
	logic signed [CW-1:0] coord_x = '0;
	logic signed [CW-1:0] coord_y = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 accepted;
	logic                 is_started;
	logic                 is_stopped;
	logic [AW-1:0]        path_length;
	logic [AW-1:0]        start_distance_sum;
	logic [NW-1:0]        point_count;
	logic signed [CW-1:0] final_x;
	logic signed [CW-1:0] final_y;
	logic [CW:0]          return_distance;
	logic [AW-1:0]        mean_start_distance;

	track_cmd_t    pending_cmds[$];
	track_result_t expected_results[$];

	int  fail_count = 0;
	int  cmds_sent = 0;
	int  results_seen = 0;
	int  stall_left = 0;
	bit  stall_done = 0;
	bit  in_taken = 0;
	bit  sender_gap;
	int  data_cmds;
	int  pick;
	track_cmd_t    next_cmd;
	track_result_t want;

	// predictor copy of the track
	logic signed [CW-1:0] org_x = '0, org_y = '0, prev_x = '0, prev_y = '0;
	logic signed [CW-1:0] end_x = '0, end_y = '0;
	logic [AW-1:0]        len_sum = '0, org_sum = '0, mean_dist = '0;
	logic [NW-1:0]        pts = '0;
	logic [CW:0]          ret_dist = '0;
	bit                   trk_started = 0, trk_stopped = 0;

	gps_track_odometer_unit DUT (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.mode                (mode),
		.coord_x             (coord_x),
		.coord_y             (coord_y),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.accepted            (accepted),
		.is_started          (is_started),
		.is_stopped          (is_stopped),
		.path_length         (path_length),
		.start_distance_sum  (start_distance_sum),
		.point_count         (point_count),
		.final_x             (final_x),
		.final_y             (final_y),
		.return_distance     (return_distance),
		.mean_start_distance (mean_start_distance)
	);

	always #5 clk = ~clk;

	// floor of the square root, one result bit per pair of input bits
	function automatic longint unsigned isqrt_floor(longint unsigned v);
		longint unsigned rem = 0;
		longint unsigned root = 0;
		longint unsigned trial;
		for (int i = 31; i >= 0; i--) begin
			rem = (rem << 2) | ((v >> (2 * i)) & 64'd3);
			trial = (root << 2) | 64'd1;
			if (rem >= trial) begin
				rem -= trial;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	function automatic longint unsigned fix_distance(logic signed [CW-1:0] ax,
			logic signed [CW-1:0] ay, logic signed [CW-1:0] bx, logic signed [CW-1:0] by);
		longint dx;
		longint dy;
		dx = longint'(ax) - longint'(bx);
		dy = longint'(ay) - longint'(by);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		return isqrt_floor(longint'(dx * dx + dy * dy));
	endfunction

	function automatic logic [AW-1:0] sat_acc(logic [AW-1:0] a, longint unsigned b);
		longint unsigned s;
		s = longint'(a) + b;
		return (s > longint'(ACC_MAX)) ? ACC_MAX : s[AW-1:0];
	endfunction

	// fold one point into the path length, the start-distance sum and the count
	function automatic void add_fix(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
		len_sum = sat_acc(len_sum, fix_distance(x, y, prev_x, prev_y));
		org_sum = sat_acc(org_sum, fix_distance(x, y, org_x, org_y));
		pts = (pts == CNT_MAX) ? CNT_MAX : pts + 1'b1;
	endfunction

	function automatic track_result_t odometer_predict(mode_t cmd, logic signed [CW-1:0] x,
			logic signed [CW-1:0] y);
		track_result_t r;
		logic took;
		took = 1'b0;
		if (cmd == MODE_START && !trk_started && !trk_stopped) begin
			org_x = x;
			org_y = y;
			prev_x = x;
			prev_y = y;
			trk_started = 1;
			took = 1'b1;
		end else if (cmd == MODE_DATA && trk_started && !trk_stopped) begin
			add_fix(x, y);
			prev_x = x;
			prev_y = y;
			took = 1'b1;
		end else if (cmd == MODE_STOP && trk_started && !trk_stopped) begin
			add_fix(x, y);
			end_x = x;
			end_y = y;
			trk_stopped = 1;
			ret_dist = (CW+1)'(fix_distance(x, y, org_x, org_y));
			mean_dist = (pts != '0) ? org_sum / pts : '0;
			took = 1'b1;
		end
		r.took = took;
		r.started = trk_started;
		r.stopped = trk_stopped;
		r.length = len_sum;
		r.org_sum = org_sum;
		r.points = pts;
		r.fin_x = end_x;
		r.fin_y = end_y;
		r.ret_dist = ret_dist;
		r.mean_dist = mean_dist;
		return r;
	endfunction

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (act_v !== exp_v) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
		end
	endtask

	function automatic void queue_cmd(mode_t cmd, logic signed [CW-1:0] x,
			logic signed [CW-1:0] y, bit drain_first);
		track_cmd_t c;
		c.cmd = cmd;
		c.x = x;
		c.y = y;
		c.drain_first = drain_first;
		pending_cmds.push_back(c);
	endfunction

	// mix of full-range values, values near zero and the two extremes
	function automatic logic signed [CW-1:0] rand_coord();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4) return CW'($urandom);
		if (sel < 8) return CW'(int'($urandom_range(0, 1023)) - 512);
		return (sel == 8) ? XY_MIN : XY_MAX;
	endfunction

	// Driver: offer the next command at the falling edge; hold the payload until taken.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			sender_gap = (cmds_sent >= 200 && cmds_sent < 300) ? 0 :
				($urandom_range(0, 99) < 28);
			if (pending_cmds.size() != 0 && !sender_gap &&
					!(pending_cmds[0].drain_first && expected_results.size() != 0)) begin
				next_cmd = pending_cmds.pop_front();
				in_valid <= 1'b1;
				mode <= next_cmd.cmd;
				coord_x <= next_cmd.x;
				coord_y <= next_cmd.y;
				cmds_sent++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure, one long hold-off, and a window with none.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!stall_done && results_seen == 60) begin
				stall_done = 1;
				stall_left = 600;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (results_seen >= 200 && results_seen < 300) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= 28);
			end
		end
	end

	// Monitor: predict on each input transaction, check each output transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if (in_valid && in_ready)
				expected_results.push_back(odometer_predict(mode_t'(mode), coord_x, coord_y));
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected output transaction, expected none, actual path %h",
						$time, path_length);
				end else begin
					want = expected_results.pop_front();
					check_field("accepted", want.took, accepted);
					check_field("is_started", want.started, is_started);
					check_field("is_stopped", want.stopped, is_stopped);
					check_field("path_length", want.length, path_length);
					check_field("start_distance_sum", want.org_sum, start_distance_sum);
					check_field("point_count", want.points, point_count);
					check_field("final_x", want.fin_x, final_x);
					check_field("final_y", want.fin_y, final_y);
					check_field("return_distance", want.ret_dist, return_distance);
					check_field("mean_start_distance", want.mean_dist, mean_start_distance);
				end
			end
		end
	end

	initial begin
		// rejected before the track starts
		queue_cmd(MODE_DATA, XY_MAX, XY_MIN, 0);
		queue_cmd(MODE_STOP, XY_MIN, XY_MAX, 0);
		queue_cmd(MODE_IGNORE, XY_MAX, XY_MAX, 0);
		// start at the far corner, then a repeated start
		queue_cmd(MODE_START, XY_MIN, XY_MIN, 0);
		queue_cmd(MODE_START, '0, '0, 0);
		// longest possible step, then a step along one axis, a zero step and a step back to zero
		queue_cmd(MODE_DATA, XY_MAX, XY_MAX, 0);
		queue_cmd(MODE_DATA, XY_MIN, XY_MAX, 0);
		queue_cmd(MODE_DATA, XY_MIN, XY_MAX, 0);
		queue_cmd(MODE_DATA, '0, '0, 0);
		queue_cmd(MODE_IGNORE, XY_MIN, XY_MIN, 0);
		queue_cmd(MODE_DATA, CW'(-1), CW'(1), 0);
		queue_cmd(MODE_DATA, XY_MAX, XY_MIN, 0);
		queue_cmd(MODE_START, XY_MAX, XY_MAX, 0);
		// back on the start point: zero distance to start
		queue_cmd(MODE_DATA, XY_MIN, XY_MIN, 0);
		queue_cmd(MODE_DATA, CW'(1), '0, 0);

		// random track body with ignored and repeated-start noise
		data_cmds = 0;
		while (data_cmds < 360) begin
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				queue_cmd(MODE_DATA, rand_coord(), rand_coord(), data_cmds == 120);
				data_cmds++;
			end else if (pick < 95) begin
				queue_cmd(MODE_IGNORE, CW'($urandom), CW'($urandom), 0);
			end else begin
				queue_cmd(MODE_START, CW'($urandom), CW'($urandom), 0);
			end
		end

		// stop once the pipeline has drained, then everything is rejected
		queue_cmd(MODE_STOP, rand_coord(), rand_coord(), 1);
		queue_cmd(MODE_STOP, XY_MAX, XY_MAX, 0);
		queue_cmd(MODE_DATA, XY_MIN, XY_MIN, 0);
		queue_cmd(MODE_START, XY_MAX, XY_MIN, 0);
		queue_cmd(MODE_IGNORE, '0, '0, 0);
		repeat (8) queue_cmd(mode_t'($urandom_range(0, 3)), CW'($urandom), CW'($urandom), 0);

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		do @(posedge clk); while (pending_cmds.size() != 0 || in_valid);
		while (expected_results.size() != 0) @(posedge clk);
		// catch any stray output after the last expected one
		repeat (300) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
